FILE: design/fcp_pkg.sv
// Shared constants, types and reply-building functions of the command frame parser.
`default_nettype none
package fcp_pkg;

    localparam int STATIONS      = 6;
    localparam int FLAG_W        = 6;
    localparam int START_ADVANCE = 15;
    localparam logic [3:0] SKIP_LOAD = 4'(START_ADVANCE - 4);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_MEAS  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] FRAME_HEAD    = 8'h68;
    localparam logic [7:0] FRAME_TAIL    = 8'h16;
    localparam logic [7:0] CMD_START     = 8'hAA;
    localparam logic [7:0] CMD_MEASURE   = 8'hAC;
    localparam logic [7:0] REPLY_START   = 8'hAB;
    localparam logic [7:0] REPLY_MEASURE = 8'hAD;
    localparam logic [7:0] MEAS_LEN_BYTE = 8'h02;

    typedef enum logic [1:0] {
        JOB_START,
        JOB_REQ,
        JOB_MEAS
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [7:0]        station;
        logic [15:0]       meas;
        logic [7:0]        check;
        logic [FLAG_W-1:0] flags;
    } job_t;

    function automatic logic [2:0] job_last_idx(job_kind_t kind);
        logic [2:0] r;
        unique case (kind)
            JOB_START: r = 3'd4;
            JOB_REQ:   r = 3'd0;
            JOB_MEAS:  r = 3'd7;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] job_byte(job_t j, logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (j.kind == JOB_START) begin
            unique case (idx)
                3'd0:    r = FRAME_HEAD;
                3'd1:    r = REPLY_START;
                3'd2:    r = j.station;
                3'd3:    r = j.check;
                default: r = FRAME_TAIL;
            endcase
        end else if (j.kind == JOB_MEAS) begin
            unique case (idx)
                3'd0:    r = FRAME_HEAD;
                3'd1:    r = REPLY_MEASURE;
                3'd2:    r = j.station;
                3'd3:    r = MEAS_LEN_BYTE;
                3'd4:    r = j.meas[15:8];
                3'd5:    r = j.meas[7:0];
                3'd6:    r = j.check;
                default: r = FRAME_TAIL;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/fcp_if.sv
// Handshake interfaces for the input items and the result items.
`default_nettype none
interface fcp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [15:0] meas_value;

    modport source (output valid, mode, rx_byte, meas_value, input ready);
    modport sink (input valid, mode, rx_byte, meas_value, output ready);
endinterface

interface fcp_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       meas_request;
    logic [7:0] request_station;
    logic [5:0] station_flags;

    modport source (output valid, tx_valid, tx_byte, frame_last, meas_request,
                    request_station, station_flags, input ready);
    modport sink (input valid, tx_valid, tx_byte, frame_last, meas_request,
                  request_station, station_flags, output ready);
endinterface
`default_nettype wire

FILE: design/test_fixture_command_frame_parser.sv
// Top level of the command frame parser: scanner, job queue and reply emitter.
// One input item is taken every cycle while the four-entry job queue has room.
// Result items pass from the job queue through the output register.
// A reply is delivered at one result item per cycle from the output register
// while the sink is ready; a start reply has five items, a measurement eight.
// Asynchronous active-low reset empties the window, queue and flags at once.
`default_nettype none
module test_fixture_command_frame_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    fcp_in_if.sink    in_ch,
    fcp_out_if.source out_ch
);

    logic          push_valid;
    fcp_pkg::job_t push_job;
    logic          queue_full;
    logic          pop;
    logic          head_valid;
    fcp_pkg::job_t head_job;

    fcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    fcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
`default_nettype wire

FILE: design/fcp_queue.sv
// Small job queue between the frame scanner and the reply emitter.
`default_nettype none
module fcp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  fcp_pkg::job_t      push_job,
    output      logic          full,
    input  wire logic          pop,
    output      logic          head_valid,
    output      fcp_pkg::job_t head_job
);

    fcp_pkg::job_t                    mem_reg [fcp_pkg::QUEUE_DEPTH];
    logic [fcp_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [fcp_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [fcp_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [fcp_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [fcp_pkg::QUEUE_AW:0]       count_reg;
    logic [fcp_pkg::QUEUE_AW:0]       count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full       = (count_reg == (fcp_pkg::QUEUE_AW+1)'(fcp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/fcp_front.sv
// Front part: takes input items, scans the byte window and queues reply jobs.
`default_nettype none
module fcp_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fcp_in_if.sink        in_ch,
    input  wire logic     queue_full,
    output      logic     push_valid,
    output fcp_pkg::job_t push_job
);

    logic [7:0]                 win_reg [4];
    logic [7:0]                 win_next [4];
    logic [2:0]                 fill_reg;
    logic [2:0]                 fill_next;
    logic [3:0]                 skip_reg;
    logic [3:0]                 skip_next;
    logic                       await_reg;
    logic                       await_next;
    logic [7:0]                 pend_reg;
    logic [7:0]                 pend_next;
    logic [fcp_pkg::FLAG_W-1:0] flags_reg;
    logic [fcp_pkg::FLAG_W-1:0] flags_next;
    logic                       accept;
    logic [7:0]                 sum;
    logic                       good;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign sum         = win_reg[0] + win_reg[1] + win_reg[2];
    assign good        = (win_reg[0] == fcp_pkg::FRAME_HEAD)
                      && (in_ch.rx_byte == fcp_pkg::FRAME_TAIL)
                      && (sum == win_reg[3]);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            win_next[i] = win_reg[i];
        end
        fill_next  = fill_reg;
        skip_next  = skip_reg;
        await_next = await_reg;
        pend_next  = pend_reg;
        flags_next = flags_reg;
        push_valid = 1'b0;
        push_job.kind    = fcp_pkg::JOB_REQ;
        push_job.station = win_reg[2];
        push_job.meas    = in_ch.meas_value;
        push_job.check   = 8'h00;

        if (accept)
        begin
            priority if (in_ch.mode == fcp_pkg::MODE_CLEAR)
            begin
                flags_next = '0;
            end
            else if (in_ch.mode == fcp_pkg::MODE_MEAS)
            begin
                if (await_reg)
                begin
                    await_next       = 1'b0;
                    push_valid       = 1'b1;
                    push_job.kind    = fcp_pkg::JOB_MEAS;
                    push_job.station = pend_reg;
                    push_job.check   = 8'(fcp_pkg::FRAME_HEAD + fcp_pkg::REPLY_MEASURE
                                          + pend_reg + fcp_pkg::MEAS_LEN_BYTE
                                          + in_ch.meas_value[15:8]
                                          + in_ch.meas_value[7:0]);
                end
            end
            else if (in_ch.mode == fcp_pkg::MODE_BYTE)
            begin
                priority if (skip_reg != '0)
                begin
                    skip_next = skip_reg - 1'b1;
                end
                else if (fill_reg < 3'd4)
                begin
                    win_next[fill_reg[1:0]] = in_ch.rx_byte;
                    fill_next = fill_reg + 1'b1;
                end
                else if (good && win_reg[1] == fcp_pkg::CMD_START)
                begin
                    for (int i = 0; i < fcp_pkg::FLAG_W; i++)
                    begin
                        if (i < fcp_pkg::STATIONS && win_reg[2] == 8'(i))
                        begin
                            flags_next[i] = 1'b1;
                        end
                    end
                    fill_next      = 3'd0;
                    skip_next      = fcp_pkg::SKIP_LOAD;
                    push_valid     = 1'b1;
                    push_job.kind  = fcp_pkg::JOB_START;
                    push_job.check = 8'(fcp_pkg::FRAME_HEAD + fcp_pkg::REPLY_START
                                        + win_reg[2]);
                end
                else if (good && win_reg[1] == fcp_pkg::CMD_MEASURE)
                begin
                    await_next  = 1'b1;
                    pend_next   = win_reg[2];
                    win_next[0] = in_ch.rx_byte;
                    fill_next   = 3'd1;
                    push_valid  = 1'b1;
                end
                else
                begin
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = in_ch.rx_byte;
                end
            end
            else
            begin
                flags_next = flags_reg;
            end
        end
        push_job.flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg  <= '0;
            skip_reg  <= '0;
            await_reg <= 1'b0;
            pend_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            fill_reg  <= fill_next;
            skip_reg  <= skip_next;
            await_reg <= await_next;
            pend_reg  <= pend_next;
            flags_reg <= flags_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/fcp_back.sv
// Back part: turns queued jobs into result items through an output register.
`default_nettype none
module fcp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  fcp_pkg::job_t      head_job,
    output      logic          pop,
    fcp_out_if.source          out_ch
);

    logic          busy_reg;
    logic          busy_next;
    fcp_pkg::job_t job_reg;
    logic [2:0]    idx_reg;
    logic          ovalid_reg;
    logic          ovalid_next;
    fcp_pkg::job_t cur_job;
    logic [2:0]    cur_idx;
    logic          advance;
    logic          have;
    logic          last;
    logic          is_req;
    logic          tx_valid_reg;
    logic [7:0]    tx_byte_reg;
    logic          frame_last_reg;
    logic          meas_request_reg;
    logic [7:0]    request_station_reg;
    logic [5:0]    station_flags_reg;

    assign advance = !ovalid_reg || out_ch.ready;
    assign have    = busy_reg || head_valid;
    assign cur_job = busy_reg ? job_reg : head_job;
    assign cur_idx = busy_reg ? idx_reg : 3'd0;
    assign last    = (cur_idx == fcp_pkg::job_last_idx(cur_job.kind));
    assign is_req  = (cur_job.kind == fcp_pkg::JOB_REQ);
    assign pop     = advance && !busy_reg && head_valid;

    always_comb
    begin
        ovalid_next = ovalid_reg;
        busy_next   = busy_reg;
        if (advance)
        begin
            ovalid_next = have;
            busy_next   = have && !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && have)
        begin
            job_reg             <= cur_job;
            idx_reg             <= cur_idx + 1'b1;
            tx_valid_reg        <= !is_req;
            tx_byte_reg         <= fcp_pkg::job_byte(cur_job, cur_idx);
            frame_last_reg      <= last;
            meas_request_reg    <= is_req;
            request_station_reg <= is_req ? cur_job.station : 8'h00;
            station_flags_reg   <= 6'(cur_job.flags);
        end
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.tx_valid        = tx_valid_reg;
    assign out_ch.tx_byte         = tx_byte_reg;
    assign out_ch.frame_last      = frame_last_reg;
    assign out_ch.meas_request    = meas_request_reg;
    assign out_ch.request_station = request_station_reg;
    assign out_ch.station_flags   = station_flags_reg;

endmodule
`default_nettype wire

FILE: tb/sv/tb_test_fixture_command_frame_parser.sv
// Testbench of the command frame parser: random and directed byte streams checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_test_fixture_command_frame_parser;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                       tx_valid;
        logic [7:0]                 tx_byte;
        logic                       frame_last;
        logic                       meas_request;
        logic [7:0]                 request_station;
        logic [fcp_pkg::FLAG_W-1:0] station_flags;
    } reply_t;

    class reply_tracker;
        logic [7:0]                 window [4];
        int unsigned                fill;
        int unsigned                skip_left;
        bit                         awaiting;
        logic [7:0]                 pend_station;
        logic [fcp_pkg::FLAG_W-1:0] flags;
        reply_t                     expected_q [$];
        int unsigned                mismatches;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            fill = 0;
            skip_left = 0;
            awaiting = 1'b0;
            pend_station = 8'h00;
            flags = '0;
            mismatches = 0;
        endfunction

        function void push_frame(input logic [7:0] bytes [8], input int n);
            reply_t r;
            for (int i = 0; i < n; i++)
            begin
                r.tx_valid = 1'b1;
                r.tx_byte = bytes[i];
                r.frame_last = (i == n - 1);
                r.meas_request = 1'b0;
                r.request_station = 8'h00;
                r.station_flags = flags;
                expected_q.push_back(r);
            end
        endfunction

        function void take_input(input logic [1:0] mode, input logic [7:0] b,
                                 input logic [15:0] value);
            logic [7:0] bytes [8];
            logic [7:0] sum;
            logic [7:0] st;
            bit         good;
            reply_t     r;
            foreach (bytes[i]) bytes[i] = 8'h00;
            if (mode == fcp_pkg::MODE_CLEAR)
            begin
                flags = '0;
            end
            else if (mode == fcp_pkg::MODE_MEAS)
            begin
                if (awaiting)
                begin
                    awaiting = 1'b0;
                    bytes[0] = fcp_pkg::FRAME_HEAD;
                    bytes[1] = fcp_pkg::REPLY_MEASURE;
                    bytes[2] = pend_station;
                    bytes[3] = fcp_pkg::MEAS_LEN_BYTE;
                    bytes[4] = value[15:8];
                    bytes[5] = value[7:0];
                    sum = 8'h00;
                    for (int i = 0; i < 6; i++)
                        sum = sum + bytes[i];
                    bytes[6] = sum;
                    bytes[7] = fcp_pkg::FRAME_TAIL;
                    push_frame(bytes, 8);
                end
            end
            else if (mode == fcp_pkg::MODE_BYTE)
            begin
                if (skip_left > 0)
                begin
                    skip_left--;
                end
                else if (fill < 4)
                begin
                    window[fill] = b;
                    fill++;
                end
                else
                begin
                    sum = window[0] + window[1] + window[2];
                    st = window[2];
                    good = (window[0] == fcp_pkg::FRAME_HEAD)
                        && (b == fcp_pkg::FRAME_TAIL) && (sum == window[3]);
                    if (good && window[1] == fcp_pkg::CMD_START)
                    begin
                        if (st < fcp_pkg::STATIONS)
                            flags[st[2:0]] = 1'b1;
                        bytes[0] = fcp_pkg::FRAME_HEAD;
                        bytes[1] = fcp_pkg::REPLY_START;
                        bytes[2] = st;
                        bytes[3] = fcp_pkg::FRAME_HEAD + fcp_pkg::REPLY_START + st;
                        bytes[4] = fcp_pkg::FRAME_TAIL;
                        fill = 0;
                        skip_left = fcp_pkg::SKIP_LOAD;
                        push_frame(bytes, 5);
                    end
                    else if (good && window[1] == fcp_pkg::CMD_MEASURE)
                    begin
                        awaiting = 1'b1;
                        pend_station = st;
                        window[0] = b;
                        fill = 1;
                        r.tx_valid = 1'b0;
                        r.tx_byte = 8'h00;
                        r.frame_last = 1'b1;
                        r.meas_request = 1'b1;
                        r.request_station = st;
                        r.station_flags = flags;
                        expected_q.push_back(r);
                    end
                    else
                    begin
                        window[0] = window[1];
                        window[1] = window[2];
                        window[2] = window[3];
                        window[3] = b;
                    end
                end
            end
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(input string name, input int unsigned got,
                           input int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_reply(input reply_t got);
            reply_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result item 0x%0h", got));
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("tx_valid", got.tx_valid, want.tx_valid);
                compare_field("tx_byte", got.tx_byte, want.tx_byte);
                compare_field("frame_last", got.frame_last, want.frame_last);
                compare_field("meas_request", got.meas_request, want.meas_request);
                compare_field("request_station", got.request_station, want.request_station);
                compare_field("station_flags", got.station_flags, want.station_flags);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned items_sent;
    int unsigned quiet_cycles;
    reply_tracker tracker = new();

    fcp_in_if  in_ch();
    fcp_out_if out_ch();

    test_fixture_command_frame_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.tx_valid = out_ch.tx_valid;
            got.tx_byte = out_ch.tx_byte;
            got.frame_last = out_ch.frame_last;
            got.meas_request = out_ch.meas_request;
            got.request_station = out_ch.request_station;
            got.station_flags = out_ch.station_flags;
            tracker.check_reply(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] b,
                             input logic [15:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.rx_byte <= b;
        in_ch.meas_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.take_input(mode, b, value);
        if (mode != MODE_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] st, input bit corrupt);
        logic [7:0] bytes [5];
        bytes[0] = fcp_pkg::FRAME_HEAD;
        bytes[1] = cmd;
        bytes[2] = st;
        bytes[3] = fcp_pkg::FRAME_HEAD + cmd + st;
        bytes[4] = fcp_pkg::FRAME_TAIL;
        if (corrupt)
            bytes[$urandom_range(4)] ^= 8'($urandom_range(255, 1));
        foreach (bytes[i])
            send_item(fcp_pkg::MODE_BYTE, bytes[i], 16'($urandom));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(fcp_pkg::MODE_BYTE, 8'($urandom), 16'($urandom));
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned pick;
        logic [7:0]  st;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
            begin
                st = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
                send_frame(fcp_pkg::CMD_START, st, 1'b0);
                send_noise(fcp_pkg::SKIP_LOAD);
            end
            else if (pick < 66)
            begin
                send_frame(fcp_pkg::CMD_MEASURE, 8'($urandom), 1'b0);
                if ($urandom_range(3) == 0)
                    send_frame(fcp_pkg::CMD_MEASURE, 8'($urandom), 1'b0);
                send_noise($urandom_range(2));
                if ($urandom_range(4) != 0)
                    send_item(fcp_pkg::MODE_MEAS, 8'($urandom), 16'($urandom));
            end
            else if (pick < 78)
                send_frame($urandom_range(1) ? fcp_pkg::CMD_START : fcp_pkg::CMD_MEASURE,
                           8'($urandom), 1'b1);
            else if (pick < 86)
                send_frame(8'($urandom), 8'($urandom_range(7)), 1'b0);
            else if (pick < 92)
                send_noise($urandom_range(4, 1));
            else if (pick < 95)
                send_item(fcp_pkg::MODE_CLEAR, 8'($urandom), 16'($urandom));
            else if (pick < 98)
                send_item(fcp_pkg::MODE_MEAS, 8'($urandom), 16'($urandom));
            else
                send_item(MODE_UNUSED, 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = fcp_pkg::MODE_BYTE;
        in_ch.rx_byte = 8'h00;
        in_ch.meas_value = 16'h0000;
        out_ch.ready = 1'b0;
        src_idle_pct = 10;
        snk_idle_pct = 84;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(MODE_UNUSED, 8'hFF, 16'hFFFF);
        send_item(fcp_pkg::MODE_MEAS, 8'h00, 16'h1234);
        send_frame(fcp_pkg::CMD_START, 8'(fcp_pkg::STATIONS - 1), 1'b0);
        for (int i = 0; i < fcp_pkg::SKIP_LOAD; i++)
            send_item(fcp_pkg::MODE_BYTE, (i % 2) ? 8'hFF : 8'h00, 16'h0000);
        send_frame(fcp_pkg::CMD_MEASURE, 8'hFF, 1'b0);
        send_item(fcp_pkg::MODE_MEAS, 8'h00, 16'hFFFF);
        send_item(fcp_pkg::MODE_CLEAR, 8'h00, 16'h0000);

        run_random(100);
        src_idle_pct = 84;
        snk_idle_pct = 10;
        run_random(180);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(260);
        in_ch.valid <= 1'b0;

        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
